// ----- hw/rtl/servo_bus_frame_receiver_unit_assert.svh -----
// Assertion macros for the servo bus frame receiver.
// Included by the top level; expects clk and rst in scope.
`ifndef SERVO_BUS_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SERVO_BUS_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle.
`define SBFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the next cycle.
`define SBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sbfr_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// servo bus frame receiver. No dependencies.
`timescale 1ns / 1ps

package sbfr_pkg;

  localparam logic [7:0] HDR_BYTE       = 8'h55;
  localparam logic [3:0] LEN_POS        = 4'd3;
  localparam logic [7:0] LEN_MIN        = 8'd3;
  localparam logic [7:0] LEN_MAX        = 8'd7;
  localparam logic [3:0] FRAME_OVERHEAD = 4'd3;

  typedef struct packed {
    logic take;
    logic load_reply;
    logic rd_issue;
    logic load_byte;
  } sbfr_cmd_t;

  typedef struct packed {
    logic fetch;
    logic emit_start;
    logic burst_last;
  } sbfr_sts_t;

endpackage

// ----- hw/rtl/sbfr_ctrl.sv -----
// Controller for the servo bus frame receiver: sequences beat intake,
// fetch replies and frame bursts. Depends on sbfr_pkg.
`timescale 1ns / 1ps

module sbfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sbfr_pkg::sbfr_sts_t sts,
  output sbfr_pkg::sbfr_cmd_t cmd
);
  import sbfr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_REPLY = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.take       = in_valid && in_ready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take) begin
          if (sts.fetch) begin
            state_next = ST_REPLY;
          end else if (sts.emit_start) begin
            state_next = ST_READ;
          end
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          cmd.load_reply = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          cmd.load_byte = 1'b1;
          state_next    = sts.burst_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_reply || cmd.load_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/sbfr_datapath.sv -----
// Datapath for the servo bus frame receiver: hunt and frame tracking,
// frame byte store, burst counter and output beat register. Depends on sbfr_pkg.
`timescale 1ns / 1ps

module sbfr_datapath #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                func,
  input  logic [7:0]          rx_byte,
  input  sbfr_pkg::sbfr_cmd_t cmd,
  output sbfr_pkg::sbfr_sts_t sts,
  output logic                kind,
  output logic [7:0]          frame_byte,
  output logic [3:0]          byte_index,
  output logic                last,
  output logic                was_ready
);
  import sbfr_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  logic             in_frame;
  logic             in_frame_next;
  logic             header_seen;
  logic             header_seen_next;
  logic [2:0]       expected_len;
  logic [2:0]       expected_len_next;
  logic [3:0]       byte_pos;
  logic [3:0]       byte_pos_next;
  logic             frame_pending;
  logic [3:0]       cnt;
  logic [3:0]       burst_len;
  logic [7:0]       rd_data;
  logic [7:0]       store [BUFFER_DEPTH];
  logic [3:0]       pos;
  logic [3:0]       pos_inc;
  logic             wr_en;
  logic             done;
  logic             rx_take;

  assign rx_take = cmd.take && !func;

  always_comb begin
    in_frame_next     = in_frame;
    header_seen_next  = header_seen;
    expected_len_next = expected_len;
    pos               = byte_pos;
    wr_en             = 1'b0;
    done              = 1'b0;
    if (!in_frame) begin
      if (rx_byte == HDR_BYTE) begin
        if (header_seen) begin
          header_seen_next = 1'b0;
          in_frame_next    = 1'b1;
          pos              = 4'd1;
        end else begin
          header_seen_next = 1'b1;
        end
      end else begin
        header_seen_next = 1'b0;
        pos              = 4'd0;
      end
    end
    pos_inc       = pos + 4'd1;
    byte_pos_next = pos;
    if (in_frame_next) begin
      wr_en = (int'(pos) < BUFFER_DEPTH);
      if (pos == LEN_POS) begin
        expected_len_next = rx_byte[2:0];
        if (rx_byte < LEN_MIN || rx_byte > LEN_MAX) begin
          expected_len_next = LEN_MIN[2:0];
          in_frame_next     = 1'b0;
        end
      end
      byte_pos_next = pos_inc;
      if (pos_inc == {1'b0, expected_len_next} + FRAME_OVERHEAD) begin
        done          = 1'b1;
        in_frame_next = 1'b0;
      end
    end
  end

  assign sts.fetch      = func;
  assign sts.emit_start = !func && done && !frame_pending;
  assign sts.burst_last = (cnt + 4'd1 == burst_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      header_seen   <= 1'b0;
      expected_len  <= 3'd2;
      byte_pos      <= 4'd0;
      frame_pending <= 1'b0;
      cnt           <= 4'd0;
      burst_len     <= 4'd0;
    end else begin
      if (rx_take) begin
        in_frame     <= in_frame_next;
        header_seen  <= header_seen_next;
        expected_len <= expected_len_next;
        byte_pos     <= byte_pos_next;
        if (sts.emit_start) begin
          frame_pending <= 1'b1;
          cnt           <= 4'd0;
          burst_len     <= pos_inc;
        end
      end
      if (cmd.load_reply) begin
        frame_pending <= 1'b0;
      end
      if (cmd.load_byte) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && wr_en) begin
      store[pos[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= store[cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_reply) begin
      kind       <= 1'b1;
      frame_byte <= 8'd0;
      byte_index <= 4'd0;
      last       <= 1'b1;
      was_ready  <= frame_pending;
    end else if (cmd.load_byte) begin
      kind       <= 1'b0;
      frame_byte <= (cnt == 4'd0) ? HDR_BYTE : rd_data;
      byte_index <= cnt;
      last       <= sts.burst_last;
      was_ready  <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/servo_bus_frame_receiver_unit.sv -----
// Servo bus frame receiver top level: controller plus datapath.
// Depends on sbfr_pkg, sbfr_ctrl, sbfr_datapath and the assertion macro header.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid, in_ready  | func, rx_byte
//   out     | out_valid, out_ready| kind, frame_byte, byte_index, last, was_ready
//
// A received byte that completes no frame leaves the controller idle.
// A fetch is an intake, then loading the reply beat.
// A completed frame of N bytes (6..10) emits N beats unless an earlier frame is
// still pending; each beat is a store read, then a load of the output register.
// The input stalls during a fetch reply or frame burst; those states also hold
// while the output register is full and not taken. Reset clears all control state.
`timescale 1ns / 1ps

`include "servo_bus_frame_receiver_unit_assert.svh"

module servo_bus_frame_receiver_unit #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] frame_byte,
  output logic [3:0] byte_index,
  output logic       last,
  output logic       was_ready
);
  import sbfr_pkg::*;

  sbfr_cmd_t cmd;
  sbfr_sts_t sts;
  logic      emitting;
  logic      last_load;
  logic      beat_zero;

  sbfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbfr_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last),
    .was_ready  (was_ready)
  );

  assign emitting  = cmd.rd_issue || cmd.load_byte || cmd.load_reply;
  assign last_load = cmd.load_byte && sts.burst_last;
  assign beat_zero = out_valid && !kind && (byte_index == 4'd0);

  `SBFR_ASSERT_NOW(a_no_take_in_burst, cmd.take, !emitting, "beat taken while emitting")
  `SBFR_ASSERT_NEXT(a_idle_after_last, last_load, in_ready, "not idle after final frame beat")
  `SBFR_ASSERT_NOW(a_ready_only_reply, out_valid && !kind, !was_ready, "was_ready on frame beat")
  `SBFR_ASSERT_NOW(a_header_first, beat_zero, frame_byte == HDR_BYTE, "beat zero is not header")

endmodule
